// ----- rtl/msfc_pkg.sv -----
// Shared constants, codes and a saturating add helper for the modal string block.
// Used by msfc_mulq and modal_string_with_finger_contact; depends on nothing.
package msfc_pkg;

  localparam int MAX_MODES   = 128;
  localparam int COEF_FRAC   = 28;
  localparam int STATE_BITS  = 48;
  localparam int SAMPLE_BITS = 24;
  localparam int COEF_BITS   = 32;
  localparam int KINDS       = 11;

  localparam int MODE_W  = $clog2(MAX_MODES);
  localparam int CNT_W   = $clog2(MAX_MODES + 1);
  localparam int COEF_AW = $clog2(MAX_MODES * KINDS);

  // Operation codes of an input item.
  localparam logic [1:0] OP_PROCESS = 2'd0;
  localparam logic [1:0] OP_LOAD    = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_MODE_COUNT  = 2'd0;
  localparam logic [1:0] REG_FINGER_SELF = 2'd1;
  localparam logic [1:0] REG_FINGER_CROSS = 2'd2;
  localparam logic [1:0] REG_OUTPUT_GAIN = 2'd3;

  // Coefficient kinds within one mode's row.
  localparam logic [3:0] K_X1     = 4'd0;
  localparam logic [3:0] K_X2     = 4'd1;
  localparam logic [3:0] K_Y1     = 4'd2;
  localparam logic [3:0] K_Y2     = 4'd3;
  localparam logic [3:0] K_PHI0   = 4'd4;
  localparam logic [3:0] K_PHI1   = 4'd5;
  localparam logic [3:0] K_ALPHA0 = 4'd6;
  localparam logic [3:0] K_ALPHA1 = 4'd7;
  localparam logic [3:0] K_BETA0  = 4'd8;
  localparam logic [3:0] K_BETA1  = 4'd9;
  localparam logic [3:0] K_BRIDGE = 4'd10;

  typedef logic signed [STATE_BITS-1:0] state_t;
  typedef logic signed [COEF_BITS-1:0]  coef_t;

  // Two's complement add, saturated to the state width.
  function automatic state_t sat_add(input state_t a, input state_t b);
    logic signed [STATE_BITS:0] s;
    s = {a[STATE_BITS-1], a} + {b[STATE_BITS-1], b};
    if (s[STATE_BITS] != s[STATE_BITS-1]) begin
      sat_add = s[STATE_BITS] ? {1'b1, {(STATE_BITS-1){1'b0}}}
                              : {1'b0, {(STATE_BITS-1){1'b1}}};
    end else begin
      sat_add = s[STATE_BITS-1:0];
    end
  endfunction

endpackage

// ----- rtl/msfc_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// Stand-alone; instantiated for the coefficient, mode state and prediction stores.
module msfc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/msfc_mulq.sv -----
// Multi-cycle fixed-point multiplier: round(x * c / 2^COEF_FRAC), ties away
// from zero, saturated to the state or sample width. Depends on msfc_pkg.
module msfc_mulq (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic                   narrow_i,
  input  msfc_pkg::state_t       x_i,
  input  msfc_pkg::coef_t        c_i,
  output logic                   done_o,
  output msfc_pkg::state_t       y_o
);
  import msfc_pkg::*;

  localparam int LO_W   = COEF_BITS;
  localparam int HI_W   = STATE_BITS - LO_W;
  localparam int PROD_W = STATE_BITS + COEF_BITS;
  localparam int RES_W  = PROD_W - COEF_FRAC;

  logic [3:0]            stage_q;
  logic                  neg_q, narrow_q;
  logic [STATE_BITS-1:0] ux_q;
  logic [COEF_BITS-1:0]  uc_q;
  logic [LO_W+COEF_BITS-1:0] pl_q;
  logic [HI_W+COEF_BITS-1:0] ph_q;
  state_t                y_q;

  logic [PROD_W-1:0] prod;
  logic [RES_W-1:0]  mag, lim;
  logic [STATE_BITS-1:0] mag_s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else begin
      stage_q <= {stage_q[2:0], start_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q    <= x_i[STATE_BITS-1] ^ c_i[COEF_BITS-1];
      narrow_q <= narrow_i;
      ux_q     <= x_i[STATE_BITS-1] ? STATE_BITS'(-x_i) : STATE_BITS'(x_i);
      uc_q     <= c_i[COEF_BITS-1] ? COEF_BITS'(-c_i) : COEF_BITS'(c_i);
    end
    if (stage_q[0]) begin
      pl_q <= ux_q[LO_W-1:0] * uc_q;
    end
    if (stage_q[1]) begin
      ph_q <= ux_q[STATE_BITS-1:LO_W] * uc_q;
    end
    if (stage_q[2]) begin
      y_q <= neg_q ? state_t'(-mag_s) : state_t'(mag_s);
    end
  end

  always_comb begin
    prod = {ph_q, {LO_W{1'b0}}} + PROD_W'(pl_q) + (PROD_W'(1) << (COEF_FRAC - 1));
    lim  = narrow_q ? ((RES_W'(1) << (SAMPLE_BITS - 1)) - RES_W'(1) + RES_W'(neg_q))
                    : ((RES_W'(1) << (STATE_BITS - 1)) - RES_W'(1) + RES_W'(neg_q));
    mag  = prod[PROD_W-1:COEF_FRAC];
    if (mag > lim) begin
      mag = lim;
    end
    mag_s = mag[STATE_BITS-1:0];
  end

  assign done_o = stage_q[3];
  assign y_o    = y_q;

endmodule

// ----- rtl/modal_string_with_finger_contact.sv -----
// Top level of the modal string resonator bank with one finger contact point.
// Depends on msfc_pkg, msfc_ram and msfc_mulq.
//
// Each process item (operation 0) runs two passes over the active modes,
// min(mode_count, 128) of them, and then delivers one sample_out item; load
// and clear items give no result. All products go through one shared
// multi-cycle multiplier. Each product passes the sequencer states in turn:
// S_READ reads the coefficient RAM, S_MUL starts the multiplier and S_WAIT
// waits for its result; the finger force and output products take their
// coefficients from the configuration registers instead. Each pass computes
// five products per mode, the finger force and the output take three more,
// and S_PUT then places the result, waiting while a full output register is
// not yet taken. Load and clear items complete in the idle state that accepts
// them. Mode states live in a RAM with a valid bit per mode, so reset and clear
// items take effect at once with no clearing pass. The next item is accepted
// while an earlier result still waits in the output register; a finished
// sample only stalls the block if that register is still full.
module modal_string_with_finger_contact (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    operation_i,
  input  logic [msfc_pkg::MODE_W-1:0]   mode_index_i,
  input  logic [3:0]                    coef_kind_i,
  input  logic signed [31:0]            coef_value_i,
  input  logic signed [msfc_pkg::SAMPLE_BITS-1:0] force_in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [msfc_pkg::SAMPLE_BITS-1:0] sample_out_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [1:0]                    cfg_index_i,
  input  logic [31:0]                   cfg_data_i
);
  import msfc_pkg::*;

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_WAIT = 3'd3;
  localparam logic [2:0] S_PUT  = 3'd4;

  // Phases of one process item.
  localparam logic [1:0] PH_P1  = 2'd0;
  localparam logic [1:0] PH_FIN = 2'd1;
  localparam logic [1:0] PH_P2  = 2'd2;
  localparam logic [1:0] PH_OUT = 2'd3;

  localparam int SW = 2 * STATE_BITS;

  // Configuration registers.
  logic [7:0] mode_count_q;
  coef_t      fself_q, fcross_q, ogain_q;

  // Sequencer state.
  logic [2:0]         state_q, state_d;
  logic [1:0]         phase_q, phase_d;
  logic [2:0]         step_q, step_d;
  logic [CNT_W-1:0]   mode_q, mode_d, n_q, n_d;
  logic [COEF_AW-1:0] base_q, base_d;
  state_t fext_q, fext_d, acc_q, acc_d, newd_q, newd_d, sum_q, sum_d, f1_q, f1_d;
  logic   vrd_q, vrd_d;
  logic [MAX_MODES-1:0] valid_q, valid_d;
  logic   out_valid_q, out_valid_d;
  logic signed [SAMPLE_BITS-1:0] sample_q, sample_d;

  // Memories and multiplier.
  logic               coef_we, coef_re;
  logic [COEF_AW-1:0] coef_waddr, coef_raddr;
  logic [COEF_BITS-1:0] coef_rdata;
  logic               st_we, st_re, pr_we, pr_re;
  logic [SW-1:0]      st_wdata, st_rdata, pr_wdata, pr_rdata;
  logic [3:0]         kind;
  logic               mul_start, mul_done;
  state_t             mul_x, mul_y, z_r, v_r, pd_r, pv_r, s_add;
  coef_t              mul_c;
  logic               in_acc;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign sample_out_o = sample_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_count_q <= '0;
      fself_q      <= '0;
      fcross_q     <= '0;
      ogain_q      <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_MODE_COUNT:   mode_count_q <= cfg_data_i[7:0];
        REG_FINGER_SELF:  fself_q      <= cfg_data_i;
        REG_FINGER_CROSS: fcross_q     <= cfg_data_i;
        REG_OUTPUT_GAIN:  ogain_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Loads write the coefficient RAM directly from the idle state.
  assign coef_we    = in_acc && (operation_i == OP_LOAD) && (coef_kind_i <= K_BRIDGE);
  assign coef_waddr = COEF_AW'(mode_index_i * KINDS) + COEF_AW'(coef_kind_i);

  // Coefficient kind used by each step of the two mode passes.
  always_comb begin
    kind = K_X1;
    if (phase_q == PH_P1) begin
      case (step_q)
        3'd0:    kind = K_X1;
        3'd1:    kind = K_X2;
        3'd2:    kind = K_Y1;
        3'd3:    kind = K_Y2;
        default: kind = K_PHI1;
      endcase
    end else begin
      case (step_q)
        3'd0:    kind = K_ALPHA0;
        3'd1:    kind = K_ALPHA1;
        3'd2:    kind = K_BETA0;
        3'd3:    kind = K_BETA1;
        default: kind = K_BRIDGE;
      endcase
    end
  end

  assign coef_raddr = base_q + COEF_AW'(kind);
  assign coef_re    = (state_q == S_READ);
  assign st_re      = (state_q == S_READ) && (phase_q == PH_P1) && (step_q == 3'd0);
  assign pr_re      = (state_q == S_READ) && (phase_q == PH_P2) && (step_q == 3'd0);

  // A mode never written since reset or the last clear reads as zero.
  assign z_r  = vrd_q ? st_rdata[SW-1:STATE_BITS] : '0;
  assign v_r  = vrd_q ? st_rdata[STATE_BITS-1:0] : '0;
  assign pd_r = pr_rdata[SW-1:STATE_BITS];
  assign pv_r = pr_rdata[STATE_BITS-1:0];

  // Multiplier operand selection.
  always_comb begin
    mul_x = sum_q;
    mul_c = coef_t'(coef_rdata);
    unique case (phase_q)
      PH_P1: begin
        case (step_q)
          3'd0, 3'd2: mul_x = z_r;
          3'd1, 3'd3: mul_x = v_r;
          default:    mul_x = newd_q;
        endcase
      end
      PH_P2: begin
        case (step_q)
          3'd0, 3'd2: mul_x = fext_q;
          3'd1, 3'd3: mul_x = f1_q;
          default:    mul_x = newd_q;
        endcase
      end
      PH_FIN: begin
        mul_x = (step_q == 3'd0) ? sum_q : fext_q;
        mul_c = (step_q == 3'd0) ? fself_q : fcross_q;
      end
      default: begin
        mul_x = sum_q;
        mul_c = ogain_q;
      end
    endcase
  end

  assign mul_start = (state_q == S_MUL);
  assign s_add     = sat_add(acc_q, mul_y);

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    step_d  = step_q;
    mode_d  = mode_q;
    n_d     = n_q;
    base_d  = base_q;
    fext_d  = fext_q;
    acc_d   = acc_q;
    newd_d  = newd_q;
    sum_d   = sum_q;
    f1_d    = f1_q;
    vrd_d   = vrd_q;
    valid_d = valid_q;
    out_valid_d = out_valid_q && !out_ready_i;
    sample_d = sample_q;
    st_we   = 1'b0;
    pr_we   = 1'b0;
    st_wdata = {newd_q, s_add};
    pr_wdata = {newd_q, s_add};

    unique case (state_q)
      S_IDLE: begin
        if (in_acc && operation_i == OP_CLEAR) begin
          valid_d = '0;
        end else if (in_acc && operation_i == OP_PROCESS) begin
          n_d    = (mode_count_q > 8'(MAX_MODES)) ? CNT_W'(MAX_MODES)
                                                   : CNT_W'(mode_count_q);
          fext_d = {{(STATE_BITS-SAMPLE_BITS){force_in_i[SAMPLE_BITS-1]}}, force_in_i};
          sum_d  = '0;
          mode_d = '0;
          base_d = '0;
          step_d = '0;
          phase_d = (n_d == '0) ? PH_FIN : PH_P1;
          state_d = S_READ;
        end
      end
      S_READ: begin
        if (step_q == 3'd0) begin
          vrd_d = valid_q[mode_q[MODE_W-1:0]];
        end
        state_d = S_MUL;
      end
      S_MUL: begin
        state_d = S_WAIT;
      end
      S_WAIT: begin
        if (mul_done) begin
          state_d = S_READ;
          step_d  = step_q + 3'd1;
          unique case (phase_q)
            PH_P1: begin
              case (step_q)
                3'd0, 3'd2: acc_d = mul_y;
                3'd1: newd_d = s_add;
                3'd3: pr_we = 1'b1;
                default: sum_d = sat_add(sum_q, mul_y);
              endcase
            end
            PH_P2: begin
              case (step_q)
                3'd0: acc_d = sat_add(pd_r, mul_y);
                3'd1: newd_d = s_add;
                3'd2: acc_d = sat_add(pv_r, mul_y);
                3'd3: begin
                  st_we = 1'b1;
                  valid_d[mode_q[MODE_W-1:0]] = 1'b1;
                end
                default: sum_d = sat_add(sum_q, mul_y);
              endcase
            end
            PH_FIN: begin
              if (step_q == 3'd0) begin
                acc_d = mul_y;
              end else begin
                f1_d   = s_add;
                sum_d  = '0;
                mode_d = '0;
                base_d = '0;
                step_d = '0;
                phase_d = (n_q == '0) ? PH_OUT : PH_P2;
              end
            end
            default: begin
              state_d = S_PUT;
            end
          endcase
          // Advance to the next mode after the fifth product of a pass.
          if ((phase_q == PH_P1 || phase_q == PH_P2) && step_q == 3'd4) begin
            step_d = '0;
            mode_d = mode_q + CNT_W'(1);
            base_d = base_q + COEF_AW'(KINDS);
            if (mode_d == n_q) begin
              mode_d = '0;
              base_d = '0;
              sum_d  = (phase_q == PH_P1) ? sum_d : sum_d;
              phase_d = (phase_q == PH_P1) ? PH_FIN : PH_OUT;
            end
          end
        end
      end
      S_PUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          sample_d    = mul_y[SAMPLE_BITS-1:0];
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_P1;
      step_q      <= '0;
      mode_q      <= '0;
      n_q         <= '0;
      base_q      <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      step_q      <= step_d;
      mode_q      <= mode_d;
      n_q         <= n_d;
      base_q      <= base_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fext_q   <= fext_d;
    acc_q    <= acc_d;
    newd_q   <= newd_d;
    sum_q    <= sum_d;
    f1_q     <= f1_d;
    vrd_q    <= vrd_d;
    sample_q <= sample_d;
  end

  msfc_ram #(.Width(COEF_BITS), .Depth(MAX_MODES * KINDS)) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (coef_we),
    .waddr_i (coef_waddr),
    .wdata_i (coef_value_i),
    .re_i    (coef_re),
    .raddr_i (coef_raddr),
    .rdata_o (coef_rdata)
  );

  // Mode displacement and velocity, written for each mode during pass two.
  msfc_ram #(.Width(SW), .Depth(MAX_MODES)) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (mode_q[MODE_W-1:0]),
    .wdata_i (st_wdata),
    .re_i    (st_re),
    .raddr_i (mode_q[MODE_W-1:0]),
    .rdata_o (st_rdata)
  );

  // Predicted displacement and velocity, handed from pass one to pass two.
  msfc_ram #(.Width(SW), .Depth(MAX_MODES)) u_pred_ram (
    .clk_i   (clk_i),
    .we_i    (pr_we),
    .waddr_i (mode_q[MODE_W-1:0]),
    .wdata_i (pr_wdata),
    .re_i    (pr_re),
    .raddr_i (mode_q[MODE_W-1:0]),
    .rdata_o (pr_rdata)
  );

  msfc_mulq u_mulq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .narrow_i (phase_q == PH_OUT),
    .x_i      (mul_x),
    .c_i      (mul_c),
    .done_o   (mul_done),
    .y_o      (mul_y)
  );

  // A new result appears only from the output placement state.
  a_out_from_put: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_PUT))
    else $error("result raised outside output placement");

  // The multiplier finishes only while the sequencer waits for it.
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> state_q == S_WAIT)
    else $error("multiplier result arrived unexpectedly");

  // The mode counter stays below the active count during the passes.
  a_mode_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE && (phase_q == PH_P1 || phase_q == PH_P2)) |-> mode_q < n_q)
    else $error("mode index out of range");

  // State and prediction RAMs are never written in the same cycle.
  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(st_we && pr_we))
    else $error("both state stores written at once");

endmodule
